/* hdl/ssws_pkg.sv */
// Shared constants, types and helpers of the subarray sum window search core.
package ssws_pkg;

	localparam int DEPTH      = 64;
	localparam int VALUE_BITS = 16;
	localparam int ADDR_W     = $clog2(DEPTH);
	// Window positions run from 0 to DEPTH + 1.
	localparam int POS_W      = $clog2(DEPTH + 2);
	// A window sum never exceeds DEPTH full-scale values.
	localparam int SUM_W      = VALUE_BITS + ADDR_W;
	localparam int TGT_W      = 32;
	localparam int CMP_W      = (SUM_W > TGT_W) ? SUM_W : TGT_W;
	localparam int OUT_IDX_W  = 7;
	localparam int RUN_W      = 2 * OUT_IDX_W;
	localparam int DATA_W     = 32;
	localparam int PADDR_W    = 3;

	localparam logic [TGT_W-1:0] TARGET_RESET = 32'd1;
	localparam logic             REG_TARGET   = 1'b0;

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_WRD   = 5'b00010,
		ST_WEX   = 5'b00100,
		ST_ORD   = 5'b01000,
		ST_OSHOW = 5'b10000
	} state_t;

	// Zero-extends or truncates a window position to the reported index width.
	function automatic logic [OUT_IDX_W-1:0] to_idx(input logic [POS_W-1:0] p);
		logic [POS_W+OUT_IDX_W-1:0] w;
		w = {{OUT_IDX_W{1'b0}}, p};
		return w[OUT_IDX_W-1:0];
	endfunction

endpackage

/* hdl/subarray_sum_window_search_core.sv */
// Top level of the subarray sum window search core: loader, window walk and result readout.
//
// The block takes a sequence of positive values, one word per cycle while in_ready is high, and
// stores them in a 64-entry value memory; the word flagged is_last is stored too and starts
// the search. A two-pointer window then walks the stored values: it grows while its sum is
// below target_sum and shrinks from the left while the sum is above. Each move of the window
// first reads the value memory at both window ends and then updates the pointers and the
// sum, and a search of n values makes at most 2n+1 moves. Every window that sums exactly to
// target_sum is recorded in a run memory; if there is none, every window with the least
// excess over the target is recorded instead. The runs are then read out of the run memory
// in order of first index; each result word is read from the run memory and then held until
// out_ready takes it. When no window reaches the target, a single result word with found low
// is given. While results are being read out, the words of the next sequence may already be
// loaded; a final word taken in that phase is held and its search starts as soon as the last
// result is taken. Values past the 64th of a sequence are dropped. target_sum sits at byte
// address 0 of the APB-style port and must be written only while the block is idle.
module subarray_sum_window_search_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ssws_pkg::PADDR_W-1:0]    paddr,
	input  logic [ssws_pkg::DATA_W-1:0]     pwdata,
	output logic [ssws_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ssws_pkg::VALUE_BITS-1:0] value,
	input  logic                            is_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ssws_pkg::OUT_IDX_W-1:0]  first_index,
	output logic [ssws_pkg::OUT_IDX_W-1:0]  last_index,
	output logic                            exact,
	output logic                            found,
	output logic                            last_result
);
	import ssws_pkg::*;

	// Configuration.
	logic [TGT_W-1:0] target_q;
	logic             cfg_wr;

	// Control.
	state_t            state_q;
	logic [POS_W-1:0]  load_cnt_q;
	logic [POS_W-1:0]  n_q;
	logic [POS_W-1:0]  left_q;
	logic [POS_W-1:0]  right_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  best_q;
	logic              best_vld_q;
	logic              exact_q;
	logic [POS_W-1:0]  run_cnt_q;
	logic [ADDR_W-1:0] out_k_q;
	logic              pend_q;

	// Memories and their registered read data.
	logic [VALUE_BITS-1:0] val_mem [DEPTH];
	logic [VALUE_BITS-1:0] vr_q;
	logic [VALUE_BITS-1:0] vl_q;
	logic [RUN_W-1:0]      run_mem [DEPTH];
	logic [RUN_W-1:0]      run_rd_q;

	// Datapath and handshake signals.
	logic              in_fire;
	logic              out_fire;
	logic              not_full;
	logic [POS_W-1:0]  ld_cnt_nx;
	logic              start_walk;
	logic              out_last;
	logic [POS_W-1:0]  r_inc;
	logic [POS_W-1:0]  l_dec;
	logic [POS_W-1:0]  right_nx;
	logic [CMP_W-1:0]  sum_ext;
	logic [CMP_W-1:0]  tgt_ext;
	logic              grow;
	logic              over;
	logic [SUM_W-1:0]  add_v;
	logic [SUM_W-1:0]  ex;
	logic              run_hit;
	logic              run_clr;
	logic              run_we;
	logic [ADDR_W-1:0] run_wa;
	logic              walk_done;

	// The configuration port never stalls.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_TARGET);
	assign prdata = (paddr[PADDR_W-1] == REG_TARGET) ? target_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_wr) begin
			target_q <= pwdata;
		end
	end

	// Input words are taken while loading and while results are read out, unless a final
	// word is already waiting for its search.
	assign in_ready  = !pend_q && (state_q == ST_LOAD || state_q == ST_ORD ||
		state_q == ST_OSHOW);
	assign in_fire   = in_valid && in_ready;
	assign not_full  = (load_cnt_q < POS_W'(DEPTH));
	assign ld_cnt_nx = load_cnt_q + POS_W'(in_fire && not_full);

	assign out_valid = (state_q == ST_OSHOW);
	assign out_fire  = out_valid && out_ready;
	assign out_last  = (run_cnt_q == '0) || (POS_W'(out_k_q) + POS_W'(1) == run_cnt_q);

	// A search starts on a final word taken while loading, or when the last result of the
	// previous search is taken and a final word has arrived during its readout.
	assign start_walk = (in_fire && is_last && state_q == ST_LOAD) ||
		(out_fire && out_last && (pend_q || (in_fire && is_last)));

	// Window step. The read data holds the element just past the right end and the
	// element at the left end; past the last element the grow step adds zero.
	assign r_inc   = right_q + POS_W'(1);
	assign l_dec   = left_q - POS_W'(1);
	assign sum_ext = CMP_W'(sum_q);
	assign tgt_ext = CMP_W'(target_q);
	assign grow    = (left_q > right_q) || (sum_ext < tgt_ext);
	assign over    = sum_ext > tgt_ext;
	assign add_v   = (r_inc <= n_q) ? SUM_W'(vr_q) : '0;
	assign ex      = SUM_W'(sum_ext - tgt_ext);

	always_comb begin
		run_hit = 1'b0;
		run_clr = 1'b0;
		if (state_q == ST_WEX && !grow) begin
			if (over) begin
				if (!exact_q) begin
					if (!best_vld_q || ex < best_q) begin
						run_hit = 1'b1;
						run_clr = 1'b1;
					end else if (ex == best_q) begin
						run_hit = 1'b1;
					end
				end
			end else begin
				// The first exact window drops all excess runs found so far.
				run_hit = 1'b1;
				run_clr = !exact_q;
			end
		end
	end

	assign run_we    = run_hit && (run_clr || run_cnt_q < POS_W'(DEPTH));
	assign run_wa    = run_clr ? '0 : run_cnt_q[ADDR_W-1:0];
	assign right_nx  = (grow || !over) ? r_inc : right_q;
	assign walk_done = (state_q == ST_WEX) && (right_nx > n_q);

	// Value memory: written by the loader, read at both window ends during the walk. The
	// loader is stalled for the whole walk, so writes and reads never meet.
	always_ff @(posedge clk) begin
		if (in_fire && not_full) begin
			val_mem[load_cnt_q[ADDR_W-1:0]] <= value;
		end
		if (state_q == ST_WRD) begin
			vr_q <= val_mem[right_q[ADDR_W-1:0]];
			vl_q <= val_mem[l_dec[ADDR_W-1:0]];
		end
	end

	// Run memory: written during the walk, read during the readout.
	always_ff @(posedge clk) begin
		if (run_we) begin
			run_mem[run_wa] <= {to_idx(left_q), to_idx(right_q)};
		end
		if (state_q == ST_ORD) begin
			run_rd_q <= run_mem[out_k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			n_q        <= '0;
			left_q     <= POS_W'(1);
			right_q    <= '0;
			sum_q      <= '0;
			best_q     <= '1;
			best_vld_q <= 1'b0;
			exact_q    <= 1'b0;
			run_cnt_q  <= '0;
			out_k_q    <= '0;
			pend_q     <= 1'b0;
		end else begin
			load_cnt_q <= start_walk ? '0 : ld_cnt_nx;

			if (start_walk) begin
				pend_q <= 1'b0;
			end else if (in_fire && is_last && state_q != ST_LOAD) begin
				pend_q <= 1'b1;
			end

			if (start_walk) begin
				// An empty window just before the first element; its first move adds it.
				state_q    <= ST_WRD;
				n_q        <= ld_cnt_nx;
				left_q     <= POS_W'(1);
				right_q    <= '0;
				sum_q      <= '0;
				best_vld_q <= 1'b0;
				exact_q    <= 1'b0;
				run_cnt_q  <= '0;
			end else begin
				unique case (state_q)
					ST_LOAD: begin
						state_q <= ST_LOAD;
					end
					ST_WRD: begin
						state_q <= ST_WEX;
					end
					ST_WEX: begin
						if (grow) begin
							sum_q <= sum_q + add_v;
						end else if (over) begin
							sum_q  <= sum_q - SUM_W'(vl_q);
							left_q <= left_q + POS_W'(1);
							if (run_clr) begin
								best_q     <= ex;
								best_vld_q <= 1'b1;
							end
						end else begin
							sum_q   <= sum_q + add_v - SUM_W'(vl_q);
							left_q  <= left_q + POS_W'(1);
							exact_q <= 1'b1;
						end
						right_q <= right_nx;
						if (run_we) begin
							run_cnt_q <= run_clr ? POS_W'(1) : run_cnt_q + POS_W'(1);
						end
						if (walk_done) begin
							state_q <= ST_ORD;
							out_k_q <= '0;
						end else begin
							state_q <= ST_WRD;
						end
					end
					ST_ORD: begin
						state_q <= ST_OSHOW;
					end
					ST_OSHOW: begin
						if (out_fire) begin
							if (out_last) begin
								state_q <= ST_LOAD;
							end else begin
								state_q <= ST_ORD;
								out_k_q <= out_k_q + ADDR_W'(1);
							end
						end
					end
					default: begin
						state_q <= ST_LOAD;
					end
				endcase
			end
		end
	end

	assign found       = (run_cnt_q != '0);
	assign first_index = found ? run_rd_q[RUN_W-1:OUT_IDX_W] : '0;
	assign last_index  = found ? run_rd_q[OUT_IDX_W-1:0] : '0;
	assign exact       = found && exact_q;
	assign last_result = out_last;

`ifndef SYNTHESIS
	// Every update step is followed by another read or by the readout.
	a_walk_alternates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WEX) |=> (state_q == ST_WRD || state_q == ST_ORD))
		else $error("window walk left its read/update cycle");

	// The right end never passes the last element while the walk still reads.
	a_right_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRD) |-> (right_q <= n_q))
		else $error("window right end past the sequence during a read");

	a_run_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		run_cnt_q <= POS_W'(DEPTH))
		else $error("run count beyond the run memory depth");

	// A new search starts clean and hands the load counter back to the next sequence.
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		start_walk |=> (state_q == ST_WRD && run_cnt_q == '0 && load_cnt_q == '0 &&
			!pend_q))
		else $error("search did not start from a clean state");

	// An exact window always leaves the search in exact mode.
	a_exact_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WEX && !grow && !over) |=> exact_q)
		else $error("exact window did not set exact mode");
`endif

endmodule
